[sv/tcce_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package tcce_pkg;

    // Row and column arithmetic widths, sized for a buffer of up to 4096 lines
    // of 256 columns plus headroom for sums such as top + count.
    localparam int ROW_W = 13;
    localparam int COL_W = 9;
    localparam int LIN_W = ROW_W + COL_W;

    typedef enum logic [3:0] {
        OP_READ        = 4'd0,
        OP_PUT         = 4'd1,
        OP_RUN_PUT     = 4'd2,
        OP_LOAD        = 4'd3,
        OP_SCROLL_UP   = 4'd4,
        OP_SCROLL_DOWN = 4'd5,
        OP_CLEAR       = 4'd6,
        OP_MOVE        = 4'd7,
        OP_REPORT      = 4'd8,
        OP_SB_CLEAR    = 4'd9,
        OP_NOOP        = 4'd10
    } t_op;

    localparam logic [1:0] CFG_COLUMNS = 2'd0;
    localparam logic [1:0] CFG_VISIBLE = 2'd1;
    localparam logic [1:0] CFG_LINES   = 2'd2;
    localparam logic [1:0] CFG_ATTR    = 2'd3;

    typedef struct packed {
        logic [3:0]  operation;
        logic [8:0]  row;
        logic [6:0]  column;
        logic [6:0]  element_index;
        logic [8:0]  top;
        logic [8:0]  bottom;
        logic [6:0]  left;
        logic [6:0]  right;
        logic [9:0]  line_count;
        logic [15:0] cell_req;
    } t_in_word;

    typedef struct packed {
        logic        status;
        logic [15:0] read_value;
        logic [7:0]  report_columns;
        logic [9:0]  report_rows;
        logic [7:0]  report_attr;
    } t_out_word;

    // Work plan for one command: an optional copy pass, then an optional fill pass.
    typedef struct packed {
        logic             status;
        logic             is_read;
        logic             is_report;
        logic [ROW_W-1:0] cp_h;
        logic [COL_W-1:0] cp_w;
        logic [ROW_W-1:0] cp_dst_row;
        logic [ROW_W-1:0] cp_src_row;
        logic [COL_W-1:0] cp_dst_col;
        logic [COL_W-1:0] cp_src_col;
        logic             cp_rdown;
        logic             cp_cdown;
        logic [ROW_W-1:0] f_h;
        logic [COL_W-1:0] f_w;
        logic [ROW_W-1:0] f_row;
        logic [COL_W-1:0] f_col;
        logic [15:0]      f_val;
    } t_plan;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PLAN,
        ST_READ,
        ST_CP_RD,
        ST_CP_WR,
        ST_FILL,
        ST_DONE
    } t_state;

endpackage
`default_nettype wire

[sv/tcce_cell_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
module tcce_cell_ram #(
    parameter int DEPTH = 65536,
    parameter int AW    = 16
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [15:0]   i_wdata,
    input  wire logic          i_re,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [15:0]   o_rdata
);
    logic [15:0] r_mem [DEPTH];
    logic [15:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

[sv/tcce_plan.sv]
`timescale 1ns / 1ps
`default_nettype none
module tcce_plan (
    input  wire tcce_pkg::t_in_word              i_req,
    input  wire logic [tcce_pkg::COL_W-1:0]      i_cols,
    input  wire logic [tcce_pkg::ROW_W-1:0]      i_lines,
    input  wire logic [tcce_pkg::ROW_W-1:0]      i_vis,
    output tcce_pkg::t_plan                      o_plan
);
    import tcce_pkg::*;

    t_op              op;
    logic [ROW_W-1:0] row, top, bot, n, base, b1, botc, nn, lim, h, hmax;
    logic [COL_W-1:0] col, idx, lft, rgt, rgtc, w, wmax;
    logic             full;

    always_comb begin
        op   = t_op'(i_req.operation);
        row  = ROW_W'(i_req.row);
        top  = ROW_W'(i_req.top);
        bot  = ROW_W'(i_req.bottom);
        n    = ROW_W'(i_req.line_count);
        col  = COL_W'(i_req.column);
        idx  = COL_W'(i_req.element_index);
        lft  = COL_W'(i_req.left);
        rgt  = COL_W'(i_req.right);
        base = i_lines - i_vis;
        b1   = bot + ROW_W'(1);
        botc = (bot >= i_vis) ? i_vis - ROW_W'(1) : bot;
        rgtc = (rgt >= i_cols) ? i_cols - COL_W'(1) : rgt;
        full = (top == '0) && (b1 == i_vis);
        lim  = (op == OP_RUN_PUT) ? i_vis : i_lines;
        h    = botc - top + ROW_W'(1);
        w    = rgtc - lft + COL_W'(1);
        hmax = i_vis - row;
        wmax = i_cols - col;
        nn   = '0;

        o_plan       = '0;
        o_plan.f_val = i_req.cell_req;

        case (op)
            OP_READ, OP_PUT: begin
                if (row >= i_vis || col >= i_cols) begin
                    o_plan.status = 1'b1;
                end else if (op == OP_READ) begin
                    o_plan.is_read    = 1'b1;
                    o_plan.cp_src_row = base + row;
                    o_plan.cp_src_col = col;
                end else begin
                    o_plan.f_h   = ROW_W'(1);
                    o_plan.f_w   = COL_W'(1);
                    o_plan.f_row = base + row;
                    o_plan.f_col = col;
                end
            end
            OP_RUN_PUT, OP_LOAD: begin
                if (col >= i_cols || row >= lim) begin
                    o_plan.status = 1'b1;
                end else if (col + idx < i_cols) begin
                    o_plan.f_h   = ROW_W'(1);
                    o_plan.f_w   = COL_W'(1);
                    o_plan.f_row = ((op == OP_RUN_PUT) ? base : '0) + row;
                    o_plan.f_col = col + idx;
                end
            end
            OP_SCROLL_UP, OP_SCROLL_DOWN: begin
                o_plan.cp_w = i_cols;
                o_plan.f_w  = i_cols;
                if (full && op == OP_SCROLL_UP) begin
                    nn                = (n > i_lines) ? i_lines : n;
                    o_plan.cp_h       = i_lines - nn;
                    o_plan.cp_src_row = nn;
                    o_plan.f_h        = nn;
                    o_plan.f_row      = i_lines - nn;
                end else if (full) begin
                    nn                = (n > i_vis) ? i_vis : n;
                    o_plan.cp_h       = i_vis - nn;
                    o_plan.cp_dst_row = base + nn;
                    o_plan.cp_src_row = base;
                    o_plan.cp_rdown   = 1'b1;
                    o_plan.f_h        = nn;
                    o_plan.f_row      = base;
                end else if (b1 > i_vis || top + n >= i_vis || top + n > b1) begin
                    o_plan.status = 1'b1;
                end else if (op == OP_SCROLL_UP) begin
                    o_plan.cp_h       = b1 - n - top;
                    o_plan.cp_dst_row = base + top;
                    o_plan.cp_src_row = base + top + n;
                    o_plan.f_h        = n;
                    o_plan.f_row      = base + b1 - n;
                end else begin
                    o_plan.cp_h       = b1 - top - n;
                    o_plan.cp_dst_row = base + top + n;
                    o_plan.cp_src_row = base + top;
                    o_plan.cp_rdown   = 1'b1;
                    o_plan.f_h        = n;
                    o_plan.f_row      = base + top;
                end
            end
            OP_CLEAR: begin
                if (top <= botc && lft <= rgtc) begin
                    o_plan.f_h   = h;
                    o_plan.f_w   = w;
                    o_plan.f_row = base + top;
                    o_plan.f_col = lft;
                end
            end
            OP_MOVE: begin
                if (top <= botc && lft <= rgtc && row < i_vis && col < i_cols) begin
                    o_plan.cp_h       = (h > hmax) ? hmax : h;
                    o_plan.cp_w       = (w > wmax) ? wmax : w;
                    o_plan.cp_dst_row = base + row;
                    o_plan.cp_src_row = base + top;
                    o_plan.cp_dst_col = col;
                    o_plan.cp_src_col = lft;
                    o_plan.cp_rdown   = !(row < top);
                    o_plan.cp_cdown   = col > lft;
                end
            end
            OP_REPORT: begin
                o_plan.is_report = 1'b1;
            end
            OP_SB_CLEAR: begin
                o_plan.f_h   = base;
                o_plan.f_w   = i_cols;
                o_plan.f_val = '0;
            end
            default: begin
            end
        endcase
    end
endmodule
`default_nettype wire

[sv/text_console_cell_engine.sv]
`timescale 1ns / 1ps
`default_nettype none
// Text console cell store. Pulse start while busy is low to issue one command
// word; exactly one result word follows, shown on o_word for the single cycle
// in which o_valid is high, and it must be taken then since the receiver
// cannot stall it. All cells live in one single-port-write, one-read RAM of
// MAX_COLUMNS*MAX_LINES words. After reset the block sweeps that RAM to zero,
// one cell per cycle, holding busy high until all MAX_COLUMNS*MAX_LINES cells
// (65536 at defaults) are cleared. Configuration writes are taken during
// the sweep. Each command passes through a plan state, then a read, copy
// or fill phase, then a done state that raises the strobe; report, no-op and
// rejected commands skip the middle phase. Scrolls and moves copy cells
// through the RAM one at a time (read, then write back), and fills write
// 1 cell per cycle. A full-screen scroll down of the default 80x25 screen
// moves only its visible rows, while a full-screen scroll up shifts all
// 512 buffer lines. busy drops the cycle after the strobe.
module text_console_cell_engine #(
    parameter int MAX_COLUMNS = 128,
    parameter int MAX_LINES   = 512
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire tcce_pkg::t_in_word   i_word,
    output logic                      o_valid,
    output tcce_pkg::t_out_word       o_word,
    input  wire logic                 i_cfg_we,
    input  wire logic [1:0]           i_cfg_idx,
    input  wire logic [9:0]           i_cfg_data
);
    import tcce_pkg::*;

    localparam int DEPTH = MAX_COLUMNS * MAX_LINES;
    localparam int AW    = $clog2(DEPTH);

    // configuration registers, raw as written
    logic [7:0] r_column_count;
    logic [9:0] r_visible_rows;
    logic [9:0] r_total_lines;
    logic [7:0] r_default_attr;

    t_state           r_state, n_state;
    t_in_word         r_req;
    t_plan            r_plan, w_plan;
    logic [ROW_W-1:0] r_ri, n_ri;
    logic [COL_W-1:0] r_ci, n_ci;
    logic [AW-1:0]    r_clr, n_clr;

    logic [COL_W-1:0] w_cols;
    logic [ROW_W-1:0] w_lines, w_vis;

    logic [ROW_W-1:0] w_roff, w_src_row, w_dst_row, w_f_row;
    logic [COL_W-1:0] w_coff, w_src_col, w_dst_col, w_f_col;
    logic [LIN_W-1:0] w_src_lin, w_dst_lin, w_f_lin;
    logic             w_cp_last_c, w_cp_last_r, w_f_last_c, w_f_last_r;

    logic             w_we, w_re;
    logic [AW-1:0]    w_waddr;
    logic [15:0]      w_wdata, w_rdata;

    // effective geometry, clamped to legal ranges
    always_comb begin
        if (r_column_count == '0) begin
            w_cols = COL_W'(1);
        end else if (COL_W'(r_column_count) > COL_W'(MAX_COLUMNS)) begin
            w_cols = COL_W'(MAX_COLUMNS);
        end else begin
            w_cols = COL_W'(r_column_count);
        end
        if (r_total_lines == '0) begin
            w_lines = ROW_W'(1);
        end else if (ROW_W'(r_total_lines) > ROW_W'(MAX_LINES)) begin
            w_lines = ROW_W'(MAX_LINES);
        end else begin
            w_lines = ROW_W'(r_total_lines);
        end
        if (r_visible_rows == '0) begin
            w_vis = ROW_W'(1);
        end else if (ROW_W'(r_visible_rows) > w_lines) begin
            w_vis = w_lines;
        end else begin
            w_vis = ROW_W'(r_visible_rows);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_column_count <= 8'd80;
            r_visible_rows <= 10'd25;
            r_total_lines  <= 10'd512;
            r_default_attr <= 8'd7;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_COLUMNS: r_column_count <= i_cfg_data[7:0];
                CFG_VISIBLE: r_visible_rows <= i_cfg_data;
                CFG_LINES:   r_total_lines  <= i_cfg_data;
                CFG_ATTR:    r_default_attr <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    tcce_plan u_plan (
        .i_req   (r_req),
        .i_cols  (w_cols),
        .i_lines (w_lines),
        .i_vis   (w_vis),
        .o_plan  (w_plan)
    );

    tcce_cell_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_src_lin[AW-1:0]),
        .o_rdata (w_rdata)
    );

    // cell addresses for the current step: linear index = row * cols + col
    always_comb begin
        w_roff    = r_plan.cp_rdown ? r_plan.cp_h - ROW_W'(1) - r_ri : r_ri;
        w_coff    = r_plan.cp_cdown ? r_plan.cp_w - COL_W'(1) - r_ci : r_ci;
        w_src_row = r_plan.cp_src_row + w_roff;
        w_dst_row = r_plan.cp_dst_row + w_roff;
        w_src_col = r_plan.cp_src_col + w_coff;
        w_dst_col = r_plan.cp_dst_col + w_coff;
        w_f_row   = r_plan.f_row + r_ri;
        w_f_col   = r_plan.f_col + r_ci;
        w_src_lin = LIN_W'(w_src_row) * LIN_W'(w_cols) + LIN_W'(w_src_col);
        w_dst_lin = LIN_W'(w_dst_row) * LIN_W'(w_cols) + LIN_W'(w_dst_col);
        w_f_lin   = LIN_W'(w_f_row) * LIN_W'(w_cols) + LIN_W'(w_f_col);
        w_cp_last_c = r_ci == r_plan.cp_w - COL_W'(1);
        w_cp_last_r = r_ri == r_plan.cp_h - ROW_W'(1);
        w_f_last_c  = r_ci == r_plan.f_w - COL_W'(1);
        w_f_last_r  = r_ri == r_plan.f_h - ROW_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_ri    <= '0;
            r_ci    <= '0;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            r_ri    <= n_ri;
            r_ci    <= n_ci;
            r_clr   <= n_clr;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && start) begin
            r_req <= i_word;
        end
        if (r_state == ST_PLAN) begin
            r_plan <= w_plan;
        end
    end

    always_comb begin
        n_state = r_state;
        n_ri    = r_ri;
        n_ci    = r_ci;
        n_clr   = r_clr;
        w_we    = 1'b0;
        w_re    = 1'b0;
        w_waddr = w_f_lin[AW-1:0];
        w_wdata = r_plan.f_val;
        case (r_state)
            ST_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_clr;
                w_wdata = '0;
                n_clr   = r_clr + AW'(1);
                if (r_clr == AW'(DEPTH - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (start) begin
                    n_state = ST_PLAN;
                end
            end
            ST_PLAN: begin
                n_ri = '0;
                n_ci = '0;
                if (w_plan.is_read) begin
                    n_state = ST_READ;
                end else if (w_plan.cp_h != '0) begin
                    n_state = ST_CP_RD;
                end else if (w_plan.f_h != '0) begin
                    n_state = ST_FILL;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_READ: begin
                w_re    = 1'b1;
                n_state = ST_DONE;
            end
            ST_CP_RD: begin
                w_re    = 1'b1;
                n_state = ST_CP_WR;
            end
            ST_CP_WR: begin
                w_we    = 1'b1;
                w_waddr = w_dst_lin[AW-1:0];
                w_wdata = w_rdata;
                n_state = ST_CP_RD;
                if (!w_cp_last_c) begin
                    n_ci = r_ci + COL_W'(1);
                end else if (!w_cp_last_r) begin
                    n_ci = '0;
                    n_ri = r_ri + ROW_W'(1);
                end else begin
                    n_ci    = '0;
                    n_ri    = '0;
                    n_state = (r_plan.f_h != '0) ? ST_FILL : ST_DONE;
                end
            end
            ST_FILL: begin
                w_we = 1'b1;
                if (!w_f_last_c) begin
                    n_ci = r_ci + COL_W'(1);
                end else if (!w_f_last_r) begin
                    n_ci = '0;
                    n_ri = r_ri + ROW_W'(1);
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign busy    = r_state != ST_IDLE;
    assign o_valid = r_state == ST_DONE;

    always_comb begin
        o_word                = '0;
        o_word.status         = r_plan.status;
        o_word.read_value     = r_plan.is_read ? w_rdata : '0;
        o_word.report_columns = r_plan.is_report ? r_column_count : '0;
        o_word.report_rows    = r_plan.is_report ? r_visible_rows : '0;
        o_word.report_attr    = r_plan.is_report ? r_default_attr : '0;
    end

    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy && !o_valid))
        else $error("accepted word did not start work");

    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy |-> !w_we)
        else $error("cell store written while idle");

    a_read_then_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_READ) |=> o_valid)
        else $error("read result not delivered next cycle");
endmodule
`default_nettype wire

[dv/text_console_cell_engine_test.sv]
`timescale 1ns / 1ps
`default_nettype none
module text_console_cell_engine_test;
    import tcce_pkg::*;

    logic      i_clk;
    logic      i_rst_n;
    logic      start;
    logic      busy;
    t_in_word  i_word;
    logic      o_valid;
    t_out_word o_word;
    logic       i_cfg_we;
    logic [1:0] i_cfg_idx;
    logic [9:0] i_cfg_data;

    text_console_cell_engine dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_word     (i_word),
        .o_valid    (o_valid),
        .o_word     (o_word),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // Shadow copy of the console: the cell store plus the raw register values.
    logic [15:0] shadow_cells [0:65535];
    logic [7:0]  reg_cols;
    logic [9:0]  reg_vis;
    logic [9:0]  reg_lines;
    logic [7:0]  reg_attr;

    t_out_word expected_words[$];
    int        error_count  = 0;
    int        words_sent   = 0;
    int        words_seen   = 0;
    bit        no_gaps      = 0;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Effective geometry, registers clamped to legal ranges.
    function automatic int eff_cols();
        int c;
        c = reg_cols;
        if (c < 1) c = 1;
        if (c > 128) c = 128;
        return c;
    endfunction

    function automatic int eff_lines();
        int l;
        l = reg_lines;
        if (l < 1) l = 1;
        if (l > 512) l = 512;
        return l;
    endfunction

    function automatic int eff_vis();
        int v;
        v = reg_vis;
        if (v < 1) v = 1;
        if (v > eff_lines()) v = eff_lines();
        return v;
    endfunction

    function automatic void copy_row(int dst, int src, int cols);
        for (int c = 0; c < cols; c++) shadow_cells[dst * cols + c] = shadow_cells[src * cols + c];
    endfunction

    function automatic void fill_row(int r, int cols, logic [15:0] v);
        for (int c = 0; c < cols; c++) shadow_cells[r * cols + c] = v;
    endfunction

    // Applies one command word to the shadow store and returns its result word.
    function automatic t_out_word apply_console_cmd(t_in_word w);
        int cols, lines, vis, base;
        int row, col, idx, top, bot, lft, rgt, n, b1, h, wd, brow;
        logic [15:0] tmp [0:127];
        t_out_word r;
        cols  = eff_cols();
        lines = eff_lines();
        vis   = eff_vis();
        base  = lines - vis;
        row = w.row; col = w.column; idx = w.element_index;
        top = w.top; bot = w.bottom; lft = w.left; rgt = w.right;
        n   = w.line_count;
        r   = '0;
        case (w.operation)
            OP_READ, OP_PUT: begin
                if (row >= vis || col >= cols) begin
                    r.status = 1'b1;
                end else if (w.operation == OP_READ) begin
                    r.read_value = shadow_cells[(base + row) * cols + col];
                end else begin
                    shadow_cells[(base + row) * cols + col] = w.cell_req;
                end
            end
            OP_RUN_PUT, OP_LOAD: begin
                brow = (w.operation == OP_RUN_PUT) ? base : 0;
                if (col >= cols || row >= ((w.operation == OP_RUN_PUT) ? vis : lines)) begin
                    r.status = 1'b1;
                end else if (col + idx < cols) begin
                    shadow_cells[(brow + row) * cols + col + idx] = w.cell_req;
                end
            end
            OP_SCROLL_UP, OP_SCROLL_DOWN: begin
                b1 = bot + 1;
                if (top == 0 && b1 == vis) begin
                    // full screen: scroll up drags the scrollback along
                    if (w.operation == OP_SCROLL_UP) begin
                        if (n > lines) n = lines;
                        for (int i = 0; i + n < lines; i++) copy_row(i, i + n, cols);
                        for (int i = lines - n; i < lines; i++) fill_row(i, cols, w.cell_req);
                    end else begin
                        if (n > vis) n = vis;
                        for (int i = vis; i > n; i--) copy_row(base + i - 1, base + i - 1 - n, cols);
                        for (int i = 0; i < n; i++) fill_row(base + i, cols, w.cell_req);
                    end
                end else if (b1 > vis || top + n >= vis || top + n > b1) begin
                    r.status = 1'b1;
                end else if (w.operation == OP_SCROLL_UP) begin
                    for (int i = top; i + n < b1; i++) copy_row(base + i, base + i + n, cols);
                    for (int i = b1 - n; i < b1; i++) fill_row(base + i, cols, w.cell_req);
                end else begin
                    for (int i = b1; i > top + n; i--) copy_row(base + i - 1, base + i - 1 - n, cols);
                    for (int i = top; i < top + n; i++) fill_row(base + i, cols, w.cell_req);
                end
            end
            OP_CLEAR: begin
                if (bot >= vis) bot = vis - 1;
                if (rgt >= cols) rgt = cols - 1;
                if (top <= bot && lft <= rgt) begin
                    for (int i = top; i <= bot; i++)
                        for (int c = lft; c <= rgt; c++)
                            shadow_cells[(base + i) * cols + c] = w.cell_req;
                end
            end
            OP_MOVE: begin
                if (bot >= vis) bot = vis - 1;
                if (rgt >= cols) rgt = cols - 1;
                if (top <= bot && lft <= rgt && row < vis && col < cols) begin
                    h  = bot - top + 1;
                    wd = rgt - lft + 1;
                    if (h > vis - row) h = vis - row;
                    if (wd > cols - col) wd = cols - col;
                    // walk rows away from the overlap; each row goes through tmp
                    for (int k = 0; k < h; k++) begin
                        int i;
                        i = (row < top) ? k : h - 1 - k;
                        for (int c = 0; c < wd; c++)
                            tmp[c] = shadow_cells[(base + top + i) * cols + lft + c];
                        for (int c = 0; c < wd; c++)
                            shadow_cells[(base + row + i) * cols + col + c] = tmp[c];
                    end
                end
            end
            OP_REPORT: begin
                r.report_columns = reg_cols;
                r.report_rows    = reg_vis;
                r.report_attr    = reg_attr;
            end
            OP_SB_CLEAR: begin
                for (int i = 0; i < base * cols; i++) shadow_cells[i] = '0;
            end
            default: ;
        endcase
        return r;
    endfunction

    // Result checker: the receiver cannot stall, so every strobe is taken.
    always @(posedge i_clk) begin
        t_out_word want;
        if (i_rst_n && o_valid) begin
            words_seen++;
            if (expected_words.size() == 0) begin
                $display("%0t: unexpected result word %h", $time, o_word);
                error_count++;
            end else begin
                want = expected_words.pop_front();
                if (o_word.status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d", $time, want.status, o_word.status);
                    error_count++;
                end
                if (o_word.read_value !== want.read_value) begin
                    $display("%0t: read_value expected %h actual %h", $time,
                             want.read_value, o_word.read_value);
                    error_count++;
                end
                if (o_word.report_columns !== want.report_columns) begin
                    $display("%0t: report_columns expected %0d actual %0d", $time,
                             want.report_columns, o_word.report_columns);
                    error_count++;
                end
                if (o_word.report_rows !== want.report_rows) begin
                    $display("%0t: report_rows expected %0d actual %0d", $time,
                             want.report_rows, o_word.report_rows);
                    error_count++;
                end
                if (o_word.report_attr !== want.report_attr) begin
                    $display("%0t: report_attr expected %0d actual %0d", $time,
                             want.report_attr, o_word.report_attr);
                    error_count++;
                end
            end
        end
    end

    // Issue one command word; returns on the falling edge after acceptance.
    task automatic send_cmd(t_in_word w);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start  <= 1'b1;
        i_word <= w;
        do @(posedge i_clk); while (busy);
        expected_words.push_back(apply_console_cmd(w));
        words_sent++;
        @(negedge i_clk);
    endtask

    // Hold off until every pending result is in and the engine has settled.
    task automatic wait_drained();
        start <= 1'b0;
        while (expected_words.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
        while (busy) @(negedge i_clk);
    endtask

    // Write all four registers back to back; engine must be idle.
    task automatic set_geometry(logic [9:0] cols, logic [9:0] vis, logic [9:0] lines,
                                logic [9:0] attr);
        logic [9:0] vals [4];
        vals = '{cols, vis, lines, attr};
        wait_drained();
        for (int k = 0; k < 4; k++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= k[1:0];
            i_cfg_data <= vals[k];
            @(negedge i_clk);
        end
        i_cfg_we <= 1'b0;
        reg_cols  = cols[7:0];
        reg_vis   = vis;
        reg_lines = lines;
        reg_attr  = attr[7:0];
    endtask

    function automatic t_in_word mk(t_op op, int row = 0, int col = 0, int idx = 0,
                                    int top = 0, int bot = 0, int lft = 0, int rgt = 0,
                                    int n = 0, int cell_val = 0);
        t_in_word w;
        w.operation = op;   w.row = 9'(row);     w.column = 7'(col);
        w.element_index = 7'(idx);
        w.top = 9'(top);    w.bottom = 9'(bot);  w.left = 7'(lft);   w.right = 7'(rgt);
        w.line_count = 10'(n);   w.cell_req = 16'(cell_val);
        return w;
    endfunction

    // Random command shaped to the current geometry, with some raw noise.
    function automatic t_in_word rand_cmd();
        t_in_word w;
        logic [95:0] noise;
        int vis, cols, lines;
        vis = eff_vis(); cols = eff_cols(); lines = eff_lines();
        noise = {$urandom, $urandom, $urandom};
        w = noise[$bits(t_in_word)-1:0];
        if ($urandom_range(0, 19) == 0) w.operation = 4'($urandom_range(10, 15));
        else w.operation = 4'($urandom_range(0, 9));
        if ($urandom_range(0, 7) != 0) begin
            w.row    = (w.operation == OP_LOAD) ? 9'($urandom_range(0, lines - 1))
                                                : 9'($urandom_range(0, vis - 1));
            w.column = 7'($urandom_range(0, cols - 1));
            w.element_index = 7'($urandom_range(0, cols));
            w.top    = 9'($urandom_range(0, vis - 1));
            w.bottom = 9'($urandom_range(w.top, vis - 1));
            if ($urandom_range(0, 3) == 0) begin
                w.top = '0; w.bottom = 9'(vis - 1);
            end
            w.left       = 7'($urandom_range(0, cols - 1));
            w.right      = 7'($urandom_range(w.left, cols));
            w.line_count = 10'($urandom_range(0, vis));
        end
        return w;
    endfunction

    task automatic test_reset_defaults();
        send_cmd(mk(OP_REPORT));
        send_cmd(mk(OP_PUT, 24, 79, 0, 0, 0, 0, 0, 0, 'hFFFF));
        send_cmd(mk(OP_READ, 24, 79));
        send_cmd(mk(OP_READ, 0, 0));
        send_cmd(mk(OP_PUT, 25, 0, 0, 0, 0, 0, 0, 0, 'h1234));  // row off screen
        send_cmd(mk(OP_READ, 0, 80));                          // column off screen
    endtask

    task automatic test_small_screen_ops();
        set_geometry(10'd10, 10'd6, 10'd20, 10'h3A5);
        send_cmd(mk(OP_REPORT));
        send_cmd(mk(OP_RUN_PUT, 5, 7, 2, 0, 0, 0, 0, 0, 'hA55A));
        send_cmd(mk(OP_RUN_PUT, 5, 7, 3, 0, 0, 0, 0, 0, 'hBEEF));  // clipped off the row
        send_cmd(mk(OP_LOAD, 19, 9, 0, 0, 0, 0, 0, 0, 'h0101));
        send_cmd(mk(OP_LOAD, 20, 0, 0, 0, 0, 0, 0, 0, 'h0202));    // beyond buffer
        send_cmd(mk(OP_SCROLL_UP, 0, 0, 0, 0, 5, 0, 0, 2, 'h0720));
        send_cmd(mk(OP_SCROLL_DOWN, 0, 0, 0, 0, 5, 0, 0, 1023, 'h1F20));
        send_cmd(mk(OP_SCROLL_UP, 0, 0, 0, 1, 4, 0, 0, 1, 'h2E2E));
        send_cmd(mk(OP_SCROLL_DOWN, 0, 0, 0, 2, 6, 0, 0, 1));      // region past screen
        send_cmd(mk(OP_SCROLL_UP, 0, 0, 0, 3, 3, 0, 0, 2));        // count exceeds region
        send_cmd(mk(OP_CLEAR, 0, 0, 0, 1, 511, 3, 127, 0, 'h5555));
        send_cmd(mk(OP_CLEAR, 0, 0, 0, 4, 2, 0, 9, 0, 'h6666));    // empty rectangle
        send_cmd(mk(OP_MOVE, 2, 1, 0, 1, 4, 0, 8, 0));             // overlapping downward
        send_cmd(mk(OP_MOVE, 0, 0, 0, 2, 511, 1, 127, 0));         // overlapping upward
        send_cmd(mk(OP_SB_CLEAR));
        send_cmd(mk(OP_READ, 5, 9));
        send_cmd(mk(OP_NOOP));
        send_cmd(mk(t_op'(4'd15)));
    endtask

    task automatic test_geometry_extremes();
        // all-zero registers clamp to a single cell
        set_geometry(10'd0, 10'd0, 10'd0, 10'd0);
        send_cmd(mk(OP_PUT, 0, 0, 0, 0, 0, 0, 0, 0, 'hC3C3));
        send_cmd(mk(OP_SCROLL_UP, 0, 0, 0, 0, 0, 0, 0, 1, 'h0F0F));
        send_cmd(mk(OP_READ, 0, 0));
        send_cmd(mk(OP_REPORT));
        // oversized registers clamp to the full buffer
        set_geometry(10'h3FF, 10'h3FF, 10'h3FF, 10'h3FF);
        send_cmd(mk(OP_PUT, 511, 127, 0, 0, 0, 0, 0, 0, 'h7E7E));
        send_cmd(mk(OP_READ, 511, 127));
        send_cmd(mk(OP_SCROLL_DOWN, 0, 0, 0, 509, 511, 0, 0, 1, 'h4141));
        send_cmd(mk(OP_READ, 511, 127));
        send_cmd(mk(OP_REPORT));
        set_geometry(10'd128, 10'd512, 10'd512, 10'd255);
        send_cmd(mk(OP_CLEAR, 0, 0, 0, 510, 511, 120, 127, 0, 'h8888));
        send_cmd(mk(OP_READ, 511, 127));
        // one cheap screen row with deep scrollback: scrollback clear sweeps it
        set_geometry(10'd128, 10'd1, 10'd512, 10'd0);
        send_cmd(mk(OP_SB_CLEAR));
        send_cmd(mk(OP_LOAD, 0, 0));
    endtask

    task automatic test_random_traffic();
        for (int phase = 0; phase < 8; phase++) begin
            int lines;
            lines = $urandom_range(2, 40);
            set_geometry(10'($urandom_range(1, 16)), 10'($urandom_range(1, lines)),
                         10'(lines), 10'($urandom_range(0, 1023)));
            no_gaps = (phase % 3 == 1);
            for (int k = 0; k < 32; k++) begin
                send_cmd(rand_cmd());
                if (k == 17 && phase == 2) wait_drained();
            end
        end
        no_gaps = 0;
    endtask

    initial begin
        i_rst_n    = 1'b0;
        start      = 1'b0;
        i_word     = '0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = '0;
        i_cfg_data = '0;
        for (int i = 0; i < 65536; i++) shadow_cells[i] = '0;
        reg_cols = 80; reg_vis = 25; reg_lines = 512; reg_attr = 7;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_reset_defaults();
        test_small_screen_ops();
        test_geometry_extremes();
        test_random_traffic();

        wait_drained();
        repeat (8) @(posedge i_clk);
        $display("Ran %0d command words over directed, extreme and random geometries;",
                 words_sent);
        $display("%0d result words checked, %0d mismatches.", words_seen, error_count);
        if (error_count == 0 && expected_words.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #40ms;
        $display("simulation failed");
        $finish;
    end

endmodule
`default_nettype wire

[sim.f]
sv/tcce_pkg.sv
sv/tcce_cell_ram.sv
sv/tcce_plan.sv
sv/text_console_cell_engine.sv
dv/text_console_cell_engine_test.sv
